// ===== hw/rtl/hcb_pkg.sv =====
// shared constants and types of the huffman code builder
`default_nettype none

package hcb_pkg;

   localparam int MAX_SYMBOLS_DEF = 32;
   localparam int WEIGHT_BITS_DEF = 16;

   localparam int IN_WEIGHT_W = 16;
   localparam int CODE_W      = 31;
   localparam int LEN_W       = 5;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 56;
   localparam int RSP_PAD_W   = RSP_DATA_W - IN_WEIGHT_W - CODE_W - LEN_W;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SCAN_A,
      ST_SCAN_B,
      ST_LINK_A,
      ST_LINK_B,
      ST_NEW,
      ST_SEL,
      ST_WALK_RD,
      ST_WALK_EV,
      ST_OUT
   } hcb_state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/hcb_node_mem.sv =====
// node store of the code builder: weights and parent links with registered reads
`default_nettype none

module hcb_node_mem #(
   parameter int MAX_SYMBOLS = hcb_pkg::MAX_SYMBOLS_DEF,
   parameter int WEIGHT_BITS = hcb_pkg::WEIGHT_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic w_we,
   input  wire logic [$clog2(2*MAX_SYMBOLS)-1:0] w_addr,
   input  wire logic [((WEIGHT_BITS < hcb_pkg::IN_WEIGHT_W) ? WEIGHT_BITS
                      : hcb_pkg::IN_WEIGHT_W) + $clog2(MAX_SYMBOLS)-1:0] w_data,
   input  wire logic m_we,
   input  wire logic [$clog2(2*MAX_SYMBOLS)-1:0] m_addr,
   input  wire logic [$clog2(2*MAX_SYMBOLS)-1:0] m_parent,
   input  wire logic m_one,
   input  wire logic m_dead,
   input  wire logic [$clog2(2*MAX_SYMBOLS)-1:0] rd_addr,
   output logic [((WEIGHT_BITS < hcb_pkg::IN_WEIGHT_W) ? WEIGHT_BITS
                 : hcb_pkg::IN_WEIGHT_W) + $clog2(MAX_SYMBOLS)-1:0] rd_weight,
   output logic [$clog2(2*MAX_SYMBOLS)-1:0] rd_parent,
   output logic rd_one,
   output logic rd_dead
);
   import hcb_pkg::*;

   localparam int NODE_SLOTS = 2 * MAX_SYMBOLS;
   localparam int IDX_W      = $clog2(NODE_SLOTS);
   localparam int LEAF_W     = (WEIGHT_BITS < IN_WEIGHT_W) ? WEIGHT_BITS : IN_WEIGHT_W;
   localparam int NW         = LEAF_W + $clog2(MAX_SYMBOLS);
   localparam int META_W     = IDX_W + 2;

   logic [NW-1:0]     weight_mem [NODE_SLOTS];
   logic [META_W-1:0] meta_mem   [NODE_SLOTS];
   logic [META_W-1:0] meta_q;

   always_ff @(posedge clock) begin
      if (w_we) begin
         weight_mem[w_addr] <= w_data;
      end
      rd_weight <= weight_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (m_we) begin
         meta_mem[m_addr] <= {m_parent, m_one, m_dead};
      end
      meta_q <= meta_mem[rd_addr];
   end

   assign rd_parent = meta_q[META_W-1:2];
   assign rd_one    = meta_q[1];
   assign rd_dead   = meta_q[0];

endmodule

`default_nettype wire

// ===== hw/rtl/huffman_code_builder.sv =====
// top level: loads symbol weights, builds the huffman tree and streams one code per symbol
// loading accepts one word per cycle; the word marked last starts the build
// build: each merge runs two full scans over the filled nodes, skipping dead ones, then the
//   link steps LINK_A, LINK_B and NEW; the scans are serial as the store has one read port
// emit per code: a scan over the leaves, a read and a step per tree level, a final read, then the word
// reset clears the state machine and the symbol count; the node store is not cleared,
//   the count of filled nodes marks which entries hold data
`default_nettype none

module huffman_code_builder #(
   parameter int MAX_SYMBOLS = hcb_pkg::MAX_SYMBOLS_DEF,
   parameter int WEIGHT_BITS = hcb_pkg::WEIGHT_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   input  wire logic [hcb_pkg::REQ_DATA_W-1:0] req_tdata,   // weight[15:0]
   input  wire logic req_tlast,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   output logic [hcb_pkg::RSP_DATA_W-1:0] rsp_tdata, // symbol_weight, code, code_length, pad
   output logic      rsp_tlast
);
   import hcb_pkg::*;

   localparam int NODE_SLOTS = 2 * MAX_SYMBOLS;
   localparam int IDX_W      = $clog2(NODE_SLOTS);
   localparam int CNT_W      = $clog2(MAX_SYMBOLS + 1);
   localparam int LEAF_W     = (WEIGHT_BITS < IN_WEIGHT_W) ? WEIGHT_BITS : IN_WEIGHT_W;
   localparam int NW         = LEAF_W + $clog2(MAX_SYMBOLS);

   hcb_state_type state_ff, state_in;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  total_ff, total_in;
   logic [IDX_W-1:0]  scan_ff, scan_in;
   logic [IDX_W-1:0]  lim_ff, lim_in;
   logic              pv_ff, pv_in;
   logic [IDX_W-1:0]  pidx_ff, pidx_in;
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  best_ff, best_in;
   logic [NW-1:0]     bestw_ff, bestw_in;
   logic [IDX_W-1:0]  a_ff, a_in;
   logic [IDX_W-1:0]  b_ff, b_in;
   logic [NW-1:0]     wa_ff, wa_in;
   logic [NW-1:0]     wb_ff, wb_in;
   logic [IDX_W-1:0]  root_ff, root_in;
   logic              first_ff, first_in;
   logic [NW-1:0]     pw_ff, pw_in;
   logic [IDX_W-1:0]  pi_ff, pi_in;
   logic [CNT_W-1:0]  r_ff, r_in;
   logic [IDX_W-1:0]  node_ff, node_in;
   logic [CNT_W-1:0]  depth_ff, depth_in;
   logic [CODE_W-1:0] bit_ff, bit_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic [IN_WEIGHT_W-1:0] symw_ff, symw_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              last_ff, last_in;

   // node store ports
   logic              w_we;
   logic [IDX_W-1:0]  w_addr;
   logic [NW-1:0]     w_data;
   logic              m_we;
   logic [IDX_W-1:0]  m_addr;
   logic [IDX_W-1:0]  m_parent;
   logic              m_one;
   logic              m_dead;
   logic [IDX_W-1:0]  rd_addr;
   logic [NW-1:0]     rd_weight;
   logic [IDX_W-1:0]  rd_parent;
   logic              rd_one;
   logic              rd_dead;

   logic req_acc, rsp_acc;
   logic scan_active, scan_issue, scan_done, cand, take, a_lighter, has_room;
   logic [CNT_W-1:0] count_next;

   hcb_node_mem #(
      .MAX_SYMBOLS(MAX_SYMBOLS),
      .WEIGHT_BITS(WEIGHT_BITS)
   ) u_mem (
      .clock    (clock),
      .w_we     (w_we),
      .w_addr   (w_addr),
      .w_data   (w_data),
      .m_we     (m_we),
      .m_addr   (m_addr),
      .m_parent (m_parent),
      .m_one    (m_one),
      .m_dead   (m_dead),
      .rd_addr  (rd_addr),
      .rd_weight(rd_weight),
      .rd_parent(rd_parent),
      .rd_one   (rd_one),
      .rd_dead  (rd_dead)
   );

   assign req_tready = (state_ff == ST_LOAD);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_acc    = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, len_ff, code_ff, symw_ff};
   assign rsp_tlast  = last_ff;

   assign has_room   = (count_ff < CNT_W'(MAX_SYMBOLS));
   assign count_next = has_room ? count_ff + CNT_W'(1) : count_ff;

   // one scan engine serves both minimum searches and the sorted leaf walk
   assign scan_active = (state_ff == ST_SCAN_A) || (state_ff == ST_SCAN_B)
                        || (state_ff == ST_SEL);
   assign scan_issue  = scan_active && (scan_ff != lim_ff);
   assign scan_done   = scan_active && !scan_issue && !pv_ff;
   assign a_lighter   = (wa_ff < wb_ff);

   always_comb begin
      unique case (state_ff)
         ST_SCAN_A: cand = !rd_dead;
         ST_SCAN_B: cand = !rd_dead && (pidx_ff != a_ff);
         ST_SEL:    cand = first_ff || (rd_weight > pw_ff)
                           || ((rd_weight == pw_ff) && (pidx_ff > pi_ff));
         default:   cand = 1'b0;
      endcase
   end

   // strict compare in index order keeps the lower index on equal weights
   assign take = pv_ff && cand && (!found_ff || (rd_weight < bestw_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_acc && req_tlast) state_in = ST_SCAN_A;
         end
         ST_SCAN_A: begin
            if (scan_done) state_in = found_ff ? ST_SCAN_B : ST_SEL;
         end
         ST_SCAN_B: begin
            if (scan_done) state_in = found_ff ? ST_LINK_A : ST_SEL;
         end
         ST_LINK_A:  state_in = ST_LINK_B;
         ST_LINK_B:  state_in = ST_NEW;
         ST_NEW:     state_in = ST_SCAN_A;
         ST_SEL: begin
            if (scan_done) state_in = ST_WALK_RD;
         end
         ST_WALK_RD: state_in = (node_ff == root_ff) ? ST_OUT : ST_WALK_EV;
         ST_WALK_EV: state_in = ST_WALK_RD;
         ST_OUT: begin
            if (rsp_acc) state_in = last_ff ? ST_LOAD : ST_SEL;
         end
         default:    state_in = ST_LOAD;
      endcase
   end

   // datapath and store control
   always_comb begin
      count_in = count_ff;
      total_in = total_ff;
      scan_in  = scan_ff;
      lim_in   = lim_ff;
      pv_in    = 1'b0;
      pidx_in  = pidx_ff;
      found_in = found_ff;
      best_in  = best_ff;
      bestw_in = bestw_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      wa_in    = wa_ff;
      wb_in    = wb_ff;
      root_in  = root_ff;
      first_in = first_ff;
      pw_in    = pw_ff;
      pi_in    = pi_ff;
      r_in     = r_ff;
      node_in  = node_ff;
      depth_in = depth_ff;
      bit_in   = bit_ff;
      code_in  = code_ff;
      symw_in  = symw_ff;
      len_in   = len_ff;
      last_in  = last_ff;
      w_we     = 1'b0;
      w_addr   = IDX_W'(count_ff);
      w_data   = NW'(req_tdata[LEAF_W-1:0]);
      m_we     = 1'b0;
      m_addr   = IDX_W'(count_ff);
      m_parent = total_ff;
      m_one    = 1'b0;
      m_dead   = 1'b0;
      rd_addr  = (state_ff == ST_WALK_RD) ? node_ff : scan_ff;

      if (scan_issue) begin
         scan_in = scan_ff + IDX_W'(1);
         pv_in   = 1'b1;
         pidx_in = scan_ff;
      end
      if (take) begin
         found_in = 1'b1;
         best_in  = pidx_ff;
         bestw_in = rd_weight;
      end

      unique case (state_ff)
         ST_LOAD: begin
            if (req_acc) begin
               w_we     = has_room;
               m_we     = has_room;
               count_in = count_next;
               if (req_tlast) begin
                  total_in = IDX_W'(count_next);
                  lim_in   = IDX_W'(count_next);
                  scan_in  = '0;
                  found_in = 1'b0;
               end
            end
         end
         ST_SCAN_A: begin
            if (scan_done) begin
               a_in     = best_ff;
               wa_in    = bestw_ff;
               scan_in  = '0;
               found_in = 1'b0;
               if (!found_ff) begin
                  lim_in   = IDX_W'(count_ff);
                  first_in = 1'b1;
                  r_in     = '0;
               end
            end
         end
         ST_SCAN_B: begin
            if (scan_done) begin
               scan_in  = '0;
               found_in = 1'b0;
               if (found_ff) begin
                  b_in  = best_ff;
                  wb_in = bestw_ff;
               end else begin
                  // only one node left: it is the root
                  root_in  = a_ff;
                  lim_in   = IDX_W'(count_ff);
                  first_in = 1'b1;
                  r_in     = '0;
               end
            end
         end
         ST_LINK_A: begin
            w_we   = 1'b1;
            w_addr = total_ff;
            w_data = wa_ff + wb_ff;
            m_we   = 1'b1;
            m_addr = a_ff;
            m_one  = !a_lighter;
            m_dead = 1'b1;
         end
         ST_LINK_B: begin
            m_we   = 1'b1;
            m_addr = b_ff;
            m_one  = a_lighter;
            m_dead = 1'b1;
         end
         ST_NEW: begin
            m_we     = 1'b1;
            m_addr   = total_ff;
            total_in = total_ff + IDX_W'(1);
            lim_in   = total_ff + IDX_W'(1);
            scan_in  = '0;
            found_in = 1'b0;
         end
         ST_SEL: begin
            if (scan_done) begin
               node_in  = best_ff;
               symw_in  = IN_WEIGHT_W'(bestw_ff[LEAF_W-1:0]);
               pw_in    = bestw_ff;
               pi_in    = best_ff;
               first_in = 1'b0;
               depth_in = '0;
               bit_in   = CODE_W'(1);
               code_in  = '0;
            end
         end
         ST_WALK_RD: begin
            len_in  = LEN_W'(depth_ff);
            last_in = ((r_ff + CNT_W'(1)) == count_ff);
         end
         ST_WALK_EV: begin
            // leaf-side branch lands in the lowest bit, bits past the code width drop out
            if (rd_one) code_in = code_ff | bit_ff;
            bit_in   = bit_ff << 1;
            depth_in = depth_ff + CNT_W'(1);
            node_in  = rd_parent;
         end
         ST_OUT: begin
            if (rsp_acc) begin
               if (last_ff) begin
                  count_in = '0;
               end else begin
                  r_in     = r_ff + CNT_W'(1);
                  scan_in  = '0;
                  found_in = 1'b0;
               end
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         pv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pv_ff    <= pv_in;
      end
   end

   always_ff @(posedge clock) begin
      total_ff <= total_in;
      scan_ff  <= scan_in;
      lim_ff   <= lim_in;
      pidx_ff  <= pidx_in;
      found_ff <= found_in;
      best_ff  <= best_in;
      bestw_ff <= bestw_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      wa_ff    <= wa_in;
      wb_ff    <= wb_in;
      root_ff  <= root_in;
      first_ff <= first_in;
      pw_ff    <= pw_in;
      pi_ff    <= pi_in;
      r_ff     <= r_in;
      node_ff  <= node_in;
      depth_ff <= depth_in;
      bit_ff   <= bit_in;
      code_ff  <= code_in;
      symw_ff  <= symw_in;
      len_ff   <= len_in;
      last_ff  <= last_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/hcb_checker.sv =====
// port-level checks of the huffman code builder and the bind that attaches them
`default_nettype none

module hcb_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   input wire logic req_tready,
   input wire logic [hcb_pkg::REQ_DATA_W-1:0] req_tdata,
   input wire logic req_tlast,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic [hcb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic rsp_tlast
);
   import hcb_pkg::*;

   // loading and emitting never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready while a code word is offered");

   // the final word starts a build, so input closes right after it
   a_build_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("input still open after the final word");

   // after the last code word of a run the block is ready for a new run
   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (req_tready && !rsp_tvalid))
      else $error("block not back to loading after the final code word");

   // stalled code word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
                                        && $stable(rsp_tlast)))
      else $error("stalled code word changed");

endmodule

bind huffman_code_builder hcb_checker u_hcb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .req_tdata (req_tdata),
   .req_tlast (req_tlast),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tlast (rsp_tlast)
);

`default_nettype wire

// ===== sim/huffman_code_checker.sv =====
// checker for the huffman code builder: predicts each run of codes and compares the output words
`timescale 1ns / 1ps

module huffman_code_checker (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   input  wire logic req_tready,
   input  wire logic [hcb_pkg::REQ_DATA_W-1:0] req_tdata,   // weight[15:0]
   input  wire logic req_tlast,
   input  wire logic rsp_tvalid,
   input  wire logic rsp_tready,
   input  wire logic [hcb_pkg::RSP_DATA_W-1:0] rsp_tdata, // symbol_weight, code, code_length, pad
   input  wire logic rsp_tlast,
   output int unsigned mismatch_total,
   output int unsigned codes_left,
   output int unsigned runs_built,
   output int unsigned weights_taken,
   output int unsigned codes_checked
);
   import hcb_pkg::*;

   localparam int SYMBOLS = MAX_SYMBOLS_DEF;
   localparam int SLOTS   = 2 * SYMBOLS;
   localparam int NODE_W  = $clog2(SLOTS);
   localparam int SUM_W   = IN_WEIGHT_W + $clog2(SYMBOLS);
   localparam logic [IN_WEIGHT_W-1:0] WEIGHT_MASK =
      IN_WEIGHT_W'((64'd1 << WEIGHT_BITS_DEF) - 64'd1);

   typedef struct packed {
      logic [IN_WEIGHT_W-1:0] symbol_weight;
      logic [CODE_W-1:0]      code;
      logic [LEN_W-1:0]       code_length;
      logic                   last_code;
   } code_word_type;

   code_word_type     code_queue[$];
   logic [SUM_W-1:0]  tree_weight[SLOTS];
   logic [NODE_W-1:0] tree_parent[SLOTS];
   bit                tree_one[SLOTS];
   bit                tree_live[SLOTS];
   int                loaded_count;

   initial begin
      mismatch_total = 0;
      codes_left     = 0;
      runs_built     = 0;
      weights_taken  = 0;
      codes_checked  = 0;
      loaded_count   = 0;
   end

   // live node of least weight below limit, lower index wins ties; SLOTS if none
   function automatic int lightest_node(int limit);
      int best;
      best = SLOTS;
      for (int i = 0; i < limit && i < SLOTS; i++) begin
         if (tree_live[i] && (best == SLOTS || tree_weight[i] < tree_weight[best]))
            best = i;
      end
      return best;
   endfunction

   task automatic build_codes();
      code_word_type     by_rank[SYMBOLS];
      int                n, total, root, a, b, rank, node, depth, steps;
      logic [CODE_W-1:0] code;
      bit                merging;
      n       = loaded_count;
      total   = n;
      root    = 0;
      merging = 1'b1;
      while (merging) begin
         a = lightest_node(total);
         if (a == SLOTS) begin
            merging = 1'b0;
         end else begin
            tree_live[a] = 1'b0;
            b = lightest_node(total);
            if (b == SLOTS) begin
               root    = a;
               merging = 1'b0;
            end else begin
               tree_live[b] = 1'b0;
               if (total >= SLOTS) begin
                  merging = 1'b0;
               end else begin
                  tree_weight[total] = tree_weight[a] + tree_weight[b];
                  tree_live[total]   = 1'b1;
                  tree_parent[a]     = NODE_W'(total);
                  tree_parent[b]     = NODE_W'(total);
                  // lighter one takes the 0 branch; on a tie the second pick does
                  tree_one[a] = !(tree_weight[a] < tree_weight[b]);
                  tree_one[b] = tree_weight[a] < tree_weight[b];
                  total++;
               end
            end
         end
      end

      for (int i = 0; i < n; i++) begin
         rank = 0;
         for (int j = 0; j < n; j++) begin
            if (tree_weight[j] < tree_weight[i] || (tree_weight[j] == tree_weight[i] && j < i))
               rank++;
         end
         // leaf-side bit lands in the lsb, so the root-side bit ends up on top
         node  = i;
         depth = 0;
         steps = 0;
         code  = '0;
         while (node != root && steps < SLOTS) begin
            if (depth < CODE_W && tree_one[node])
               code[depth] = 1'b1;
            depth++;
            steps++;
            node = tree_parent[node];
         end
         by_rank[rank].symbol_weight = tree_weight[i][IN_WEIGHT_W-1:0];
         by_rank[rank].code          = code;
         by_rank[rank].code_length   = LEN_W'(depth);
         by_rank[rank].last_code     = (rank + 1 == n);
      end
      for (int r = 0; r < n; r++)
         code_queue.insert(code_queue.size(), by_rank[r]);

      runs_built++;
      loaded_count = 0;
      for (int k = 0; k < SLOTS; k++)
         tree_live[k] = 1'b0;
   endtask

   task automatic note_mismatch(string what, longint unsigned want, longint unsigned got);
      mismatch_total++;
      if (mismatch_total <= 10)
         $display("%0t: code word %0d, %s: expected %0h, got %0h",
                  $time, codes_checked, what, want, got);
   endtask

   task automatic check_code();
      code_word_type want, got;
      got.symbol_weight = rsp_tdata[IN_WEIGHT_W-1:0];
      got.code          = rsp_tdata[IN_WEIGHT_W +: CODE_W];
      got.code_length   = rsp_tdata[IN_WEIGHT_W + CODE_W +: LEN_W];
      got.last_code     = rsp_tlast;
      if (code_queue.size() == 0) begin
         note_mismatch("word with no code predicted, whole word", 0, got);
         return;
      end
      want = code_queue.pop_front();
      codes_checked++;
      if (got.symbol_weight !== want.symbol_weight)
         note_mismatch("symbol_weight", want.symbol_weight, got.symbol_weight);
      if (got.code !== want.code)
         note_mismatch("code", want.code, got.code);
      if (got.code_length !== want.code_length)
         note_mismatch("code_length", want.code_length, got.code_length);
      if (got.last_code !== want.last_code)
         note_mismatch("tlast", want.last_code, got.last_code);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         loaded_count = 0;
         for (int k = 0; k < SLOTS; k++)
            tree_live[k] = 1'b0;
         code_queue.delete();
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_code();
         if (req_tvalid && req_tready) begin
            weights_taken++;
            // weights past the symbol limit are dropped, the last flag still counts
            if (loaded_count < SYMBOLS) begin
               tree_weight[loaded_count] = SUM_W'(req_tdata[IN_WEIGHT_W-1:0] & WEIGHT_MASK);
               tree_live[loaded_count]   = 1'b1;
               loaded_count++;
            end
            if (req_tlast)
               build_codes();
         end
      end
      codes_left = code_queue.size();
   end

endmodule

// ===== sim/tb_huffman_code_builder.sv =====
// testbench top for the huffman code builder: stimulus, handshake idling and verdict
`timescale 1ns / 1ps

module tb_huffman_code_builder;
   import hcb_pkg::*;

   localparam int     SYMBOLS      = MAX_SYMBOLS_DEF;
   localparam int     HALF_PERIOD  = 6;
   localparam int     RESET_CYCLES = 12;
   localparam int     DRAIN_CYCLES = 200;
   localparam int     PHASE_WORDS  = 75;
   localparam longint LIMIT_NS     = 64'd2_000_000 * 2 * HALF_PERIOD;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // weight[15:0]
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // symbol_weight[15:0], code[46:16], code_length[51:47]
   logic                  rsp_tlast;

   int unsigned mismatch_total, codes_left, runs_built, weights_taken, codes_checked;

   int                     req_idle_pct;
   int                     rsp_idle_pct;
   int unsigned            words_sent;
   logic [IN_WEIGHT_W-1:0] run_weights[$];

   huffman_code_builder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   huffman_code_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .mismatch_total (mismatch_total),
      .codes_left     (codes_left),
      .runs_built     (runs_built),
      .weights_taken  (weights_taken),
      .codes_checked  (codes_checked)
   );

   initial begin
      clock        = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tlast    = 1'b0;
      rsp_tready   = 1'b0;
      req_idle_pct = 22;
      rsp_idle_pct = 75;
      words_sent   = 0;
   end

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   initial begin
      #(LIMIT_NS);
      $display("timeout with %0d codes still outstanding", codes_left);
      $display("Mismatches found");
      $finish;
   end

   task automatic send_word(input logic [IN_WEIGHT_W-1:0] weight, input logic last_word);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(weight);
      req_tlast  <= last_word;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      words_sent++;
   endtask

   task automatic send_run();
      foreach (run_weights[k])
         send_word(run_weights[k], k == run_weights.size() - 1);
      run_weights.delete();
   endtask

   function automatic logic [IN_WEIGHT_W-1:0] pick_weight(int style);
      case (style)
         0: return IN_WEIGHT_W'($urandom);
         1: return IN_WEIGHT_W'($urandom_range(3));            // heavy on ties
         2: return $urandom_range(1) ? {IN_WEIGHT_W{1'b1}} : IN_WEIGHT_W'($urandom_range(1));
         default: return IN_WEIGHT_W'($urandom_range(1000));
      endcase
   endfunction

   initial begin
      int shape, run_len, style, fib_a, fib_b, fib_next;
      int unsigned phase_end;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // lone symbols at both extremes, a two-leaf tree, all-equal weights,
      // and a run mixing repeated zero and full-scale weights
      run_weights = '{16'hFFFF};
      send_run();
      run_weights = '{16'h0000};
      send_run();
      run_weights = '{16'h0000, 16'hFFFF};
      send_run();
      run_weights = '{16'd7, 16'd7, 16'd7, 16'd7};
      send_run();
      run_weights = '{16'hFFFF, 16'h0000, 16'h0001, 16'h0000, 16'hFFFF};
      send_run();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_idle_pct = 22;
               rsp_idle_pct = 75;
               // more weights than the block holds: the tail is dropped
               for (int k = 0; k < SYMBOLS + 3; k++)
                  run_weights.insert(run_weights.size(), pick_weight(0));
            end
            1: begin
               req_idle_pct = 75;
               rsp_idle_pct = 22;
               // fibonacci weights, descending, give the longest codes
               fib_a = 1;
               fib_b = 1;
               for (int k = 0; k < 24; k++) begin
                  run_weights.push_front(IN_WEIGHT_W'(fib_a));
                  fib_next = fib_a + fib_b;
                  fib_a    = fib_b;
                  fib_b    = fib_next;
               end
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
               for (int k = 0; k < SYMBOLS; k++)
                  run_weights.insert(run_weights.size(), pick_weight(1));
            end
         endcase
         send_run();

         phase_end = words_sent + PHASE_WORDS;
         while (words_sent < phase_end) begin
            shape = $urandom_range(99);
            style = $urandom_range(3);
            if (shape < 6)
               run_len = 1;
            else if (shape < 80)
               run_len = $urandom_range(8, 2);
            else if (shape < 95)
               run_len = $urandom_range(20, 9);
            else
               run_len = $urandom_range(SYMBOLS + 3, 21);
            for (int k = 0; k < run_len; k++)
               run_weights.insert(run_weights.size(), pick_weight(style));
            send_run();
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (codes_left == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("built %0d trees from %0d weights and checked %0d codes,", runs_built,
               weights_taken, codes_checked);
      $display("with idle handshakes on the input side, the output side, and neither");
      if (mismatch_total == 0 && codes_left == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
